/* rtl/core/dop_pkg.sv */
// Shared types and constants for the DHCP options parser.
package dop_pkg;

  localparam int unsigned AREA_BYTES = 312;
  localparam int unsigned LEFT_W = 10;
  localparam logic [LEFT_W-1:0] AREA_INIT = LEFT_W'(AREA_BYTES);

  localparam logic [7:0] TAG_PAD = 8'd0;
  localparam logic [7:0] TAG_END = 8'd255;

  localparam logic [7:0] COOKIE [4] = '{8'd99, 8'd130, 8'd83, 8'd99};

  typedef enum logic [2:0] {
    PH_COOKIE    = 3'd0,
    PH_TAG       = 3'd1,
    PH_LENGTH    = 3'd2,
    PH_VALUE     = 3'd3,
    PH_AFTER_END = 3'd4,
    PH_ERROR     = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    KIND_COOKIE = 3'd0,
    KIND_PAD    = 3'd1,
    KIND_TAG    = 3'd2,
    KIND_LENGTH = 3'd3,
    KIND_VALUE  = 3'd4,
    KIND_END    = 3'd5,
    KIND_TRAIL  = 3'd6,
    KIND_ERROR  = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_COOKIE     = 2'd1,
    ERR_LENGTH     = 2'd2,
    ERR_NO_END     = 2'd3
  } err_t;

  // classified item passed from front to back
  typedef struct packed {
    logic [7:0] data_byte;
    logic       msg_start;
    logic       is_pad;
    logic       is_end;
    logic [3:0] cookie_hit;
  } class_t;

endpackage

/* rtl/core/dop_in_if.sv */
// Input channel: one options byte per item.
interface dop_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       msg_start;

  modport source (output valid, data_byte, msg_start, input ready);
  modport sink (input valid, data_byte, msg_start, output ready);
endinterface

/* rtl/core/dop_out_if.sv */
// Output channel: one classified byte per item.
interface dop_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] byte_kind;
  logic [7:0] option_tag;
  logic [7:0] option_length;
  logic [7:0] value_index;
  logic [7:0] byte_out;
  logic       option_last;
  logic [1:0] error_code;

  modport source (output valid, byte_kind, option_tag, option_length, value_index,
                  byte_out, option_last, error_code, input ready);
  modport sink (input valid, byte_kind, option_tag, option_length, value_index,
                byte_out, option_last, error_code, output ready);
endinterface

/* rtl/core/dop_front.sv */
// Front end: stateless classification of each incoming byte.
module dop_front (
  input  logic [7:0]      data_byte,
  input  logic            msg_start,
  output dop_pkg::class_t item
);

  always_comb begin
    item.data_byte = data_byte;
    item.msg_start = msg_start;
    item.is_pad    = (data_byte == dop_pkg::TAG_PAD);
    item.is_end    = (data_byte == dop_pkg::TAG_END);
    for (int i = 0; i < 4; i++) begin
      item.cookie_hit[i] = (data_byte == dop_pkg::COOKIE[i]);
    end
  end

endmodule

/* rtl/core/dop_queue.sv */
// Two-entry queue between classifier and parser.
module dop_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  dop_pkg::class_t push_item,
  output logic            not_full,
  input  logic            pop,
  output dop_pkg::class_t head,
  output logic            not_empty
);

  dop_pkg::class_t slots [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;

  assign not_full  = (count != 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/core/dop_back.sv */
// Back end: parser state and registered result.
module dop_back (
  input  logic               clk,
  input  logic               rst,
  input  dop_pkg::class_t    head,
  input  logic               head_valid,
  output logic               pop,
  dop_out_if.source          dst
);

  dop_pkg::phase_t           phase, phase_next, cur_phase;
  logic [1:0]                cookie_pos, cookie_pos_next, cur_pos;
  logic                      cookie_mis, cookie_mis_next, cur_mis;
  logic [dop_pkg::LEFT_W-1:0] bytes_left, bytes_left_next, cur_left, rem;
  logic [7:0]                held_tag, held_tag_next, cur_tag;
  logic [7:0]                held_length, held_length_next, cur_len;
  logic [7:0]                value_count, value_count_next, cur_vc;
  dop_pkg::err_t             sticky, sticky_next, cur_sticky;

  logic                      had_byte;
  logic                      rem_zero;
  logic                      len_too_long;
  logic [8:0]                vc_inc;
  logic                      val_done;
  logic [7:0]                b;

  dop_pkg::kind_t            kind;
  logic [7:0]                otag, olen, vidx;
  logic                      last;

  logic                      out_valid;
  logic [2:0]                out_kind;
  logic [7:0]                out_tag, out_len, out_vidx, out_byte;
  logic                      out_last;
  logic [1:0]                out_err;

  assign pop = head_valid && (!out_valid || dst.ready);
  assign b   = head.data_byte;

  // msg_start restarts the parser before the byte is parsed
  always_comb begin
    if (head.msg_start) begin
      cur_phase  = dop_pkg::PH_COOKIE;
      cur_pos    = 2'd0;
      cur_mis    = 1'b0;
      cur_left   = dop_pkg::AREA_INIT;
      cur_tag    = 8'd0;
      cur_len    = 8'd0;
      cur_vc     = 8'd0;
      cur_sticky = dop_pkg::ERR_NONE;
    end else begin
      cur_phase  = phase;
      cur_pos    = cookie_pos;
      cur_mis    = cookie_mis;
      cur_left   = bytes_left;
      cur_tag    = held_tag;
      cur_len    = held_length;
      cur_vc     = value_count;
      cur_sticky = sticky;
    end
  end

  assign had_byte     = (cur_left != '0);
  assign rem          = had_byte ? (cur_left - dop_pkg::LEFT_W'(1)) : '0;
  assign rem_zero     = (rem == '0);
  assign len_too_long = ({{(dop_pkg::LEFT_W-8){1'b0}}, b} > rem);
  assign vc_inc       = {1'b0, cur_vc} + 9'd1;
  assign val_done     = (vc_inc >= {1'b0, cur_len});

  // next state
  always_comb begin
    phase_next       = cur_phase;
    cookie_pos_next  = cur_pos;
    cookie_mis_next  = cur_mis;
    bytes_left_next  = had_byte ? rem : cur_left;
    held_tag_next    = cur_tag;
    held_length_next = cur_len;
    value_count_next = cur_vc;
    sticky_next      = cur_sticky;
    if (cur_phase == dop_pkg::PH_ERROR || cur_phase == dop_pkg::PH_AFTER_END) begin
      phase_next = cur_phase;
    end else if (!had_byte) begin
      phase_next  = dop_pkg::PH_ERROR;
      sticky_next = dop_pkg::ERR_NO_END;
    end else begin
      case (cur_phase)
        dop_pkg::PH_COOKIE: begin
          cookie_mis_next = cur_mis | ~head.cookie_hit[cur_pos];
          if (cur_pos == 2'd3) begin
            cookie_pos_next = 2'd0;
            if (cookie_mis_next) begin
              phase_next  = dop_pkg::PH_ERROR;
              sticky_next = dop_pkg::ERR_COOKIE;
            end else begin
              phase_next = dop_pkg::PH_TAG;
            end
          end else begin
            cookie_pos_next = cur_pos + 2'd1;
          end
        end
        dop_pkg::PH_TAG: begin
          if (head.is_end) begin
            phase_next = dop_pkg::PH_AFTER_END;
          end else if (rem_zero) begin
            phase_next  = dop_pkg::PH_ERROR;
            sticky_next = dop_pkg::ERR_NO_END;
          end else if (!head.is_pad) begin
            held_tag_next    = b;
            held_length_next = 8'd0;
            value_count_next = 8'd0;
            phase_next       = dop_pkg::PH_LENGTH;
          end
        end
        dop_pkg::PH_LENGTH: begin
          held_length_next = b;
          value_count_next = 8'd0;
          if (len_too_long) begin
            phase_next  = dop_pkg::PH_ERROR;
            sticky_next = dop_pkg::ERR_LENGTH;
          end else if (rem_zero) begin
            phase_next  = dop_pkg::PH_ERROR;
            sticky_next = dop_pkg::ERR_NO_END;
          end else if (b == 8'd0) begin
            phase_next = dop_pkg::PH_TAG;
          end else begin
            phase_next = dop_pkg::PH_VALUE;
          end
        end
        dop_pkg::PH_VALUE: begin
          if (rem_zero) begin
            phase_next  = dop_pkg::PH_ERROR;
            sticky_next = dop_pkg::ERR_NO_END;
          end else begin
            value_count_next = vc_inc[7:0];
            if (val_done) phase_next = dop_pkg::PH_TAG;
          end
        end
        default: begin
          phase_next  = dop_pkg::PH_ERROR;
          sticky_next = dop_pkg::ERR_NO_END;
        end
      endcase
    end
  end

  // result fields
  always_comb begin
    kind = dop_pkg::KIND_ERROR;
    otag = 8'd0;
    olen = 8'd0;
    vidx = 8'd0;
    last = 1'b0;
    if (phase_next != dop_pkg::PH_ERROR) begin
      case (cur_phase)
        dop_pkg::PH_AFTER_END: kind = dop_pkg::KIND_TRAIL;
        dop_pkg::PH_COOKIE:    kind = dop_pkg::KIND_COOKIE;
        dop_pkg::PH_TAG: begin
          otag = b;
          if (head.is_end)      kind = dop_pkg::KIND_END;
          else if (head.is_pad) kind = dop_pkg::KIND_PAD;
          else                  kind = dop_pkg::KIND_TAG;
        end
        dop_pkg::PH_LENGTH: begin
          kind = dop_pkg::KIND_LENGTH;
          otag = cur_tag;
          olen = b;
          last = (b == 8'd0);
        end
        dop_pkg::PH_VALUE: begin
          kind = dop_pkg::KIND_VALUE;
          otag = cur_tag;
          olen = cur_len;
          vidx = cur_vc;
          last = val_done;
        end
        default: kind = dop_pkg::KIND_ERROR;
      endcase
    end else begin
      otag = held_tag_next;
      olen = held_length_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= dop_pkg::PH_COOKIE;
      cookie_pos  <= 2'd0;
      cookie_mis  <= 1'b0;
      bytes_left  <= dop_pkg::AREA_INIT;
      held_tag    <= 8'd0;
      held_length <= 8'd0;
      value_count <= 8'd0;
      sticky      <= dop_pkg::ERR_NONE;
      out_valid   <= 1'b0;
    end else begin
      if (pop) begin
        phase       <= phase_next;
        cookie_pos  <= cookie_pos_next;
        cookie_mis  <= cookie_mis_next;
        bytes_left  <= bytes_left_next;
        held_tag    <= held_tag_next;
        held_length <= held_length_next;
        value_count <= value_count_next;
        sticky      <= sticky_next;
        out_valid   <= 1'b1;
      end else if (dst.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_kind <= kind;
      out_tag  <= otag;
      out_len  <= olen;
      out_vidx <= vidx;
      out_byte <= b;
      out_last <= last;
      out_err  <= (kind == dop_pkg::KIND_ERROR) ? sticky_next : dop_pkg::ERR_NONE;
    end
  end

  assign dst.valid         = out_valid;
  assign dst.byte_kind     = out_kind;
  assign dst.option_tag    = out_tag;
  assign dst.option_length = out_len;
  assign dst.value_index   = out_vidx;
  assign dst.byte_out      = out_byte;
  assign dst.option_last   = out_last;
  assign dst.error_code    = out_err;

endmodule

/* rtl/core/dhcp_option_parser.sv */
// DHCP options area parser: classifier, two-entry queue and TLV parser.
// An accepted item goes through a queue slot and then the output register; its result
// is valid the cycle after the item leaves the queue.
// Throughput: one item per cycle while the output is not stalled; state updates on pop.
// Reset clears the queue and output register and returns the parser to the cookie phase.
module dhcp_option_parser (
  input  logic      clk,
  input  logic      rst,
  dop_in_if.sink    in_item,
  dop_out_if.source out_item
);

  dop_pkg::class_t cls;
  dop_pkg::class_t head;
  logic            not_full;
  logic            not_empty;
  logic            pop;
  logic            push;

  assign in_item.ready = not_full;
  assign push          = in_item.valid && not_full;

  dop_front u_front (
    .data_byte (in_item.data_byte),
    .msg_start (in_item.msg_start),
    .item      (cls)
  );

  dop_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (cls),
    .not_full  (not_full),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty)
  );

  dop_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (not_empty),
    .pop        (pop),
    .dst        (out_item)
  );

endmodule
